// ===== hdl/rdpd_pkg.sv =====
// ============================================================================
// Rotary dial pulse decoder package
// Shared types, register indexes, frame codes and state encodings for the
// front classifier, the command queue and the frame emitter.
// ============================================================================
package rdpd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_CLOSED_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE_MS      = 3'd1;
  localparam logic [2:0] REG_MIN_PULSE_MS     = 3'd2;
  localparam logic [2:0] REG_MAX_PULSE_MS     = 3'd3;
  localparam logic [2:0] REG_DIGIT_PAUSE_MS   = 3'd4;
  localparam logic [2:0] REG_SEND_TIMEOUT_MS  = 3'd5;

  // Register reset values.
  localparam logic [9:0]  RST_CLOSED_THRESHOLD = 10'd250;
  localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd25;
  localparam logic [15:0] RST_MIN_PULSE_MS     = 16'd20;
  localparam logic [15:0] RST_MAX_PULSE_MS     = 16'd90;
  localparam logic [15:0] RST_DIGIT_PAUSE_MS   = 16'd600;
  localparam logic [15:0] RST_SEND_TIMEOUT_MS  = 16'd2500;

  // Filter and pulse constants.
  localparam logic [9:0] LEVEL_RESET = 10'd1023;
  localparam logic [3:0] PULSE_MAX   = 4'd15;
  localparam logic [3:0] PULSE_WRAP  = 4'd10;

  // Frame bytes.
  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_END   = 8'h03;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [9:0]  closed_threshold;
    logic [15:0] debounce_ms;
    logic [15:0] min_pulse_ms;
    logic [15:0] max_pulse_ms;
    logic [15:0] digit_pause_ms;
    logic [15:0] send_timeout_ms;
  } cfg_t;

  // One command from the front: either a finished digit or a send request.
  typedef struct packed {
    logic       is_send;
    logic [3:0] digit;
  } q_entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_FILT,
    F_EDGE,
    F_PAUSE,
    F_SEND
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_READ,
    B_DIGIT,
    B_END
  } back_state_t;

endpackage

// ===== hdl/rotary_dial_pulse_decoder_unit.sv =====
// ============================================================================
// Rotary dial pulse decoder unit
// Decodes dial pulses from line samples, which it filters, and emits the dialed number
// as a byte frame: start byte, ASCII digits, end byte.
// ============================================================================
// The front takes one item at a time through accept, filter, edge, pause
// and send steps, each doing a short piece of the 32-bit time arithmetic,
// and holds off new items while busy and while the command queue is full.
// A frame starts when the idle back takes its send command from the queue;
// it gives one byte per cycle for the start and end bytes while the output
// register is free, and each digit waits on a registered read of the digit store.
// Reset (synchronous, rst_n low) restores registers, filter, timers, queue.
// ============================================================================
module rotary_dial_pulse_decoder_unit #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample items.
  input  logic        in_push,
  output logic        in_full,
  input  logic [9:0]  in_sample,
  input  logic [31:0] in_now_ms,
  // Frame byte items.
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers. Writes are always taken; an unknown index
  // is simply ignored.
  rdpd_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rdpd_pkg::REG_CLOSED_THRESHOLD: cfg_nxt.closed_threshold = cfg_data[9:0];
        rdpd_pkg::REG_DEBOUNCE_MS:      cfg_nxt.debounce_ms      = cfg_data;
        rdpd_pkg::REG_MIN_PULSE_MS:     cfg_nxt.min_pulse_ms     = cfg_data;
        rdpd_pkg::REG_MAX_PULSE_MS:     cfg_nxt.max_pulse_ms     = cfg_data;
        rdpd_pkg::REG_DIGIT_PAUSE_MS:   cfg_nxt.digit_pause_ms   = cfg_data;
        rdpd_pkg::REG_SEND_TIMEOUT_MS:  cfg_nxt.send_timeout_ms  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.closed_threshold <= rdpd_pkg::RST_CLOSED_THRESHOLD;
      cfg_r.debounce_ms      <= rdpd_pkg::RST_DEBOUNCE_MS;
      cfg_r.min_pulse_ms     <= rdpd_pkg::RST_MIN_PULSE_MS;
      cfg_r.max_pulse_ms     <= rdpd_pkg::RST_MAX_PULSE_MS;
      cfg_r.digit_pause_ms   <= rdpd_pkg::RST_DIGIT_PAUSE_MS;
      cfg_r.send_timeout_ms  <= rdpd_pkg::RST_SEND_TIMEOUT_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front issues at most one command per item: a digit, or a send
  // request. It only takes an item while the queue has a free slot, so the
  // command always finds room.
  logic               q_push;
  rdpd_pkg::q_entry_t q_wr;
  logic               q_pop;
  rdpd_pkg::q_entry_t q_head;
  logic               q_full;
  logic               q_empty;

  rdpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample),
    .in_now_ms (in_now_ms),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  rdpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // The back owns the digit store and takes digits and send requests from the
  // queue strictly in the order in which the front issued them.
  rdpd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // A command is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // An accepted item always has a free queue slot for its command.
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> !q_full)
    else $error("item accepted without queue room");

  // The frame end flag only ever marks the end byte.
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (out_byte == rdpd_pkg::FRAME_END))
    else $error("last flag on a byte other than the end byte");
`endif

endmodule

// ===== hdl/rdpd_front.sv =====
// ============================================================================
// Rotary dial pulse decoder front
// Accepts line samples, filters them, debounces the contact, counts pulses
// and issues digit and send commands into the queue.
// ============================================================================
module rdpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [9:0]        in_sample,
  input  logic [31:0]       in_now_ms,
  input  rdpd_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output rdpd_pkg::q_entry_t q_data
);

  rdpd_pkg::front_state_t state_r, state_nxt;

  logic [9:0]  level_r, level_nxt;
  logic        closed_r, closed_nxt;
  logic [31:0] last_chg_r, last_chg_nxt;
  logic [31:0] close_time_r, close_time_nxt;
  logic [31:0] last_dig_r, last_dig_nxt;
  logic [3:0]  pulse_r, pulse_nxt;
  logic        pend_r, pend_nxt;
  logic [9:0]  sample_r;
  logic [31:0] now_r;

  logic        accept;
  logic [11:0] filt_sum;
  logic        closed_now;
  logic [31:0] phase;
  logic [31:0] width;
  logic [31:0] quiet;
  logic [31:0] since_dig;

  assign in_full   = (state_r != rdpd_pkg::F_IDLE) || q_full;
  assign accept    = in_push && !in_full;
  assign filt_sum  = 12'({level_r, 1'b0}) + 12'(level_r) + 12'(sample_r);
  assign closed_now = level_r < cfg.closed_threshold;
  assign phase     = now_r - last_chg_r;
  assign width     = now_r - close_time_r;
  assign quiet     = now_r - last_chg_r;
  assign since_dig = now_r - last_dig_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdpd_pkg::F_IDLE:  if (accept) state_nxt = rdpd_pkg::F_FILT;
      rdpd_pkg::F_FILT:  state_nxt = rdpd_pkg::F_EDGE;
      rdpd_pkg::F_EDGE:  state_nxt = rdpd_pkg::F_PAUSE;
      rdpd_pkg::F_PAUSE: state_nxt = rdpd_pkg::F_SEND;
      rdpd_pkg::F_SEND:  state_nxt = rdpd_pkg::F_IDLE;
      default:           state_nxt = rdpd_pkg::F_IDLE;
    endcase
  end

  // Datapath and queue outputs.
  always_comb begin
    level_nxt      = level_r;
    closed_nxt     = closed_r;
    last_chg_nxt   = last_chg_r;
    close_time_nxt = close_time_r;
    last_dig_nxt   = last_dig_r;
    pulse_nxt      = pulse_r;
    pend_nxt       = pend_r;
    q_push         = 1'b0;
    q_data         = '0;
    unique case (state_r)
      rdpd_pkg::F_FILT: begin
        level_nxt = filt_sum[11:2];
      end
      rdpd_pkg::F_EDGE: begin
        if ((closed_now != closed_r) && (phase > 32'(cfg.debounce_ms))) begin
          if (closed_now) begin
            close_time_nxt = now_r;
            pend_nxt       = 1'b0;
          end else if ((width >= 32'(cfg.min_pulse_ms)) &&
                       (width <= 32'(cfg.max_pulse_ms)) &&
                       (pulse_r < rdpd_pkg::PULSE_MAX)) begin
            pulse_nxt = pulse_r + 4'd1;
          end
          last_chg_nxt = now_r;
          closed_nxt   = closed_now;
        end
      end
      rdpd_pkg::F_PAUSE: begin
        if ((pulse_r != 4'd0) && (quiet > 32'(cfg.digit_pause_ms))) begin
          q_push         = 1'b1;
          q_data.is_send = 1'b0;
          q_data.digit   = (pulse_r >= rdpd_pkg::PULSE_WRAP) ? 4'd0 : pulse_r;
          last_dig_nxt   = now_r;
          pend_nxt       = 1'b1;
          pulse_nxt      = 4'd0;
        end
      end
      rdpd_pkg::F_SEND: begin
        if (pend_r && (since_dig > 32'(cfg.send_timeout_ms))) begin
          q_push         = 1'b1;
          q_data.is_send = 1'b1;
          pend_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rdpd_pkg::F_IDLE;
      level_r      <= rdpd_pkg::LEVEL_RESET;
      closed_r     <= 1'b0;
      last_chg_r   <= '0;
      close_time_r <= '0;
      last_dig_r   <= '0;
      pulse_r      <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      level_r      <= level_nxt;
      closed_r     <= closed_nxt;
      last_chg_r   <= last_chg_nxt;
      close_time_r <= close_time_nxt;
      last_dig_r   <= last_dig_nxt;
      pulse_r      <= pulse_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      now_r    <= in_now_ms;
    end
  end

endmodule

// ===== hdl/rdpd_queue.sv =====
// ============================================================================
// Rotary dial pulse decoder command queue
// A short first-in first-out buffer of commands between front and back.
// ============================================================================
module rdpd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rdpd_pkg::q_entry_t wr_data,
  input  logic               pop,
  output rdpd_pkg::q_entry_t rd_data,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = (rdpd_pkg::QDEPTH > 1) ? $clog2(rdpd_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(rdpd_pkg::QDEPTH + 1);

  rdpd_pkg::q_entry_t slots_r [rdpd_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(rdpd_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(rdpd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(rdpd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/rdpd_back.sv =====
// ============================================================================
// Rotary dial pulse decoder back
// Stores digits from the queue and, on a send command, plays out the frame
// through a one-entry output register.
// ============================================================================
module rdpd_back #(
  parameter int MAX_DIGITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdpd_pkg::q_entry_t q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  rdpd_pkg::back_state_t state_r, state_nxt;

  logic [3:0]       mem [MAX_DIGITS];
  logic [3:0]       rd_data_r;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_m1;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             slot_free;
  logic             wr_en;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;

  assign slot_free = !out_valid_r || out_pop;
  assign cnt_m1    = dcnt_r - CNT_W'(1);
  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdpd_pkg::B_IDLE: begin
        if (!q_empty && q_head.is_send) state_nxt = rdpd_pkg::B_START;
      end
      rdpd_pkg::B_START: begin
        if (slot_free) begin
          state_nxt = (dcnt_r == '0) ? rdpd_pkg::B_END : rdpd_pkg::B_READ;
        end
      end
      rdpd_pkg::B_READ: state_nxt = rdpd_pkg::B_DIGIT;
      rdpd_pkg::B_DIGIT: begin
        if (slot_free) begin
          state_nxt = (idx_r == cnt_m1[IDX_W-1:0]) ? rdpd_pkg::B_END : rdpd_pkg::B_READ;
        end
      end
      rdpd_pkg::B_END: begin
        if (slot_free) state_nxt = rdpd_pkg::B_IDLE;
      end
      default: state_nxt = rdpd_pkg::B_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    load      = 1'b0;
    load_byte = rdpd_pkg::FRAME_START;
    load_last = 1'b0;
    dcnt_nxt  = dcnt_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      rdpd_pkg::B_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && !q_head.is_send && (dcnt_r < CNT_W'(MAX_DIGITS))) begin
          wr_en    = 1'b1;
          dcnt_nxt = dcnt_r + CNT_W'(1);
        end
      end
      rdpd_pkg::B_START: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = rdpd_pkg::FRAME_START;
          idx_nxt   = '0;
        end
      end
      rdpd_pkg::B_READ: begin
      end
      rdpd_pkg::B_DIGIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = rdpd_pkg::ASCII_ZERO + 8'(rd_data_r);
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      rdpd_pkg::B_END: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = rdpd_pkg::FRAME_END;
          load_last = 1'b1;
          dcnt_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdpd_pkg::B_IDLE;
      dcnt_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= load_byte;
      out_last_r <= load_last;
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[dcnt_r[IDX_W-1:0]] <= q_head.digit;
    end
    rd_data_r <= mem[idx_r];
  end

endmodule
